FILE: hw/rtl/depth_to_rainbow_color_map_core_assert.svh
`ifndef DEPTH_TO_RAINBOW_COLOR_MAP_CORE_ASSERT_SVH
`define DEPTH_TO_RAINBOW_COLOR_MAP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DRCM_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DRCM_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: hw/rtl/drcm_pkg.sv
`default_nettype none

package drcm_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int DEPTH_BITS_DEFAULT = 16;
  localparam int QUOT_BITS          = 11;
  localparam int COLOR_BITS         = 8;
  localparam int CFG_INDEX_BITS     = 1;
  localparam int S_TDATA_BITS       = 16;
  localparam int M_TDATA_BITS       = 24;

  localparam logic [QUOT_BITS-1:0]  RAMP_STEPS = 11'd1530;
  localparam logic [COLOR_BITS-1:0] CHAN_MAX   = 8'hff;

  localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RESET  = 16'h0000;
  localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RESET = 16'hffff;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH = 1'b1;

  localparam logic [2:0] SEG_WHITE_RED   = 3'd0;
  localparam logic [2:0] SEG_RED_YELLOW  = 3'd1;
  localparam logic [2:0] SEG_YELLOW_GRN  = 3'd2;
  localparam logic [2:0] SEG_GRN_CYAN    = 3'd3;
  localparam logic [2:0] SEG_CYAN_BLUE   = 3'd4;
  localparam logic [2:0] SEG_BLUE_BLACK  = 3'd5;

endpackage

`default_nettype wire

FILE: hw/rtl/depth_to_rainbow_color_map_core.sv
// Maps one depth sample per beat to an RGB pixel on a six-segment rainbow ramp
// between range_low and range_high (black below range, past the end, or when
// the range is empty). Takes one beat every clock while the output is not held; each
// beat passes through three prep stages, the 11-stage restoring divider (one
// quotient bit per stage) and the output register, the first of them loaded on
// the accepting edge. Write range_low/range_high only while the pipeline is
// empty. A held output beat (m_tready low) stalls the whole pipeline.
`default_nettype none

module depth_to_rainbow_color_map_core #(
  parameter int DEPTH_BITS = drcm_pkg::DEPTH_BITS_DEFAULT
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    s_tvalid,
  output logic                                   s_tready,
  input  wire  [drcm_pkg::S_TDATA_BITS-1:0]      s_tdata,   // [15:0] depth_sample
  output logic                                   m_tvalid,
  input  wire                                    m_tready,
  output logic [drcm_pkg::M_TDATA_BITS-1:0]      m_tdata,   // [7:0] red, [15:8] green,
                                                            // [23:16] blue
  input  wire                                    cfg_we,
  input  wire  [drcm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire  [drcm_pkg::SAMPLE_BITS-1:0]       cfg_data
);

  localparam int EB = (DEPTH_BITS < drcm_pkg::SAMPLE_BITS) ? DEPTH_BITS
                                                           : drcm_pkg::SAMPLE_BITS;
  localparam int QB = drcm_pkg::QUOT_BITS;
  localparam int NW = EB + QB;
  localparam int CB = drcm_pkg::COLOR_BITS;

  logic [drcm_pkg::SAMPLE_BITS-1:0] range_low;
  logic [drcm_pkg::SAMPLE_BITS-1:0] range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= drcm_pkg::RANGE_LOW_RESET;
      range_high <= drcm_pkg::RANGE_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        drcm_pkg::REG_RANGE_LOW:  range_low  <= cfg_data;
        drcm_pkg::REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: offsets, empty-range and at-or-below-low test
  logic [EB-1:0] d_m, lo_m, hi_m;
  assign d_m  = s_tdata[EB-1:0];
  assign lo_m = range_low[EB-1:0];
  assign hi_m = range_high[EB-1:0];

  logic          vld1, blk1;
  logic [EB-1:0] diff1, den1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff1 <= d_m - lo_m;
      den1  <= hi_m - lo_m;
      blk1  <= (hi_m <= lo_m) || (d_m <= lo_m);
    end
  end

  // stage 2: scale by ramp length
  logic          vld2, blk2;
  logic [NW-1:0] prod2;
  logic [EB-1:0] den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2 <= NW'(diff1) * NW'(drcm_pkg::RAMP_STEPS);
      den2  <= den1;
      blk2  <= blk1;
    end
  end

  // stage 3 onward: divider, index 0 is the overflow-check stage
  logic          vld_pipe [0:QB];
  logic          blk_pipe [0:QB];
  logic [NW-1:0] rem_pipe [0:QB];
  logic [EB-1:0] den_pipe [0:QB];
  logic [QB-1:0] q_pipe   [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe[0] <= 1'b0;
    end else if (adv) begin
      vld_pipe[0] <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_pipe[0] <= prod2;
      den_pipe[0] <= den2;
      q_pipe[0]   <= '0;
      blk_pipe[0] <= blk2 || (prod2 >= {den2, {QB{1'b0}}});
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int K = QB - 1 - i;
    logic [NW-1:0] dsh;
    logic          ge;
    assign dsh = NW'(den_pipe[i]) << K;
    assign ge  = rem_pipe[i] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe[i+1] <= 1'b0;
      end else if (adv) begin
        vld_pipe[i+1] <= vld_pipe[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_pipe[i+1] <= ge ? (rem_pipe[i] - dsh) : rem_pipe[i];
        q_pipe[i+1]   <= {q_pipe[i][QB-2:0], ge};
        den_pipe[i+1] <= den_pipe[i];
        blk_pipe[i+1] <= blk_pipe[i];
      end
    end
  end

  // color ramp
  logic [QB-1:0] q;
  logic [2:0]    seg;
  logic [CB-1:0] lb, r_c, g_c, b_c;

  assign q   = q_pipe[QB];
  assign seg = q[QB-1:CB];
  assign lb  = q[CB-1:0];

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    case (seg)
      drcm_pkg::SEG_WHITE_RED: begin
        r_c = drcm_pkg::CHAN_MAX;
        g_c = drcm_pkg::CHAN_MAX - lb;
        b_c = drcm_pkg::CHAN_MAX - lb;
      end
      drcm_pkg::SEG_RED_YELLOW: begin
        r_c = drcm_pkg::CHAN_MAX;
        g_c = lb;
      end
      drcm_pkg::SEG_YELLOW_GRN: begin
        r_c = drcm_pkg::CHAN_MAX - lb;
        g_c = drcm_pkg::CHAN_MAX;
      end
      drcm_pkg::SEG_GRN_CYAN: begin
        g_c = drcm_pkg::CHAN_MAX;
        b_c = lb;
      end
      drcm_pkg::SEG_CYAN_BLUE: begin
        g_c = drcm_pkg::CHAN_MAX - lb;
        b_c = drcm_pkg::CHAN_MAX;
      end
      drcm_pkg::SEG_BLUE_BLACK: begin
        b_c = drcm_pkg::CHAN_MAX - lb;
      end
      default: ;
    endcase
    if (blk_pipe[QB] || (q == '0)) begin
      r_c = '0;
      g_c = '0;
      b_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld_pipe[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {b_c, g_c, r_c};
    end
  end

`include "depth_to_rainbow_color_map_core_assert.svh"

  `DRCM_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "ready low with empty output")
  `DRCM_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld1, "accepted beat not in stage 1")
  `DRCM_ASSERT_NOW(a_rem_bound, vld_pipe[QB] && !blk_pipe[QB], rem_pipe[QB] < NW'(den_pipe[QB]),
    "divider remainder not below divisor")
  `DRCM_ASSERT_NEXT(a_black_out, adv && vld_pipe[QB] && blk_pipe[QB], m_tdata == '0,
    "out-of-range beat not black")

endmodule

`default_nettype wire

FILE: sim/tb_depth_to_rainbow_color_map_core.sv
`default_nettype none

module tb_depth_to_rainbow_color_map_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEG_END        = 1536;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned HOLD_TRIGGER   = 300;
  localparam int unsigned ITEMS_PER_SET  = 222;
  localparam int unsigned NUM_SETS       = 9;

  typedef struct packed {
    logic [drcm_pkg::COLOR_BITS-1:0] blue;
    logic [drcm_pkg::COLOR_BITS-1:0] green;
    logic [drcm_pkg::COLOR_BITS-1:0] red;
  } rgb_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [drcm_pkg::S_TDATA_BITS-1:0]   s_tdata = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [drcm_pkg::M_TDATA_BITS-1:0]   m_tdata;
  logic                                cfg_we = 1'b0;
  logic [drcm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [drcm_pkg::SAMPLE_BITS-1:0]    cfg_data = '0;

  // current ramp bounds as written to the block
  logic [drcm_pkg::SAMPLE_BITS-1:0] ramp_low  = drcm_pkg::RANGE_LOW_RESET;
  logic [drcm_pkg::SAMPLE_BITS-1:0] ramp_high = drcm_pkg::RANGE_HIGH_RESET;

  logic [drcm_pkg::SAMPLE_BITS-1:0] depth_backlog[$];
  rgb_t                             expected_colors[$];

  int unsigned colors_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_tick = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;

  depth_to_rainbow_color_map_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic rgb_t rainbow_color(input logic [drcm_pkg::SAMPLE_BITS-1:0] depth,
                                         input logic [drcm_pkg::SAMPLE_BITS-1:0] lo,
                                         input logic [drcm_pkg::SAMPLE_BITS-1:0] hi);
    logic [31:0]                     v;
    logic [drcm_pkg::COLOR_BITS-1:0] lb;
    rgb_t                            c;
    c = '0;
    if (hi <= lo || depth <= lo) begin
      v = 0;
    end else begin
      v = (32'(drcm_pkg::RAMP_STEPS) * 32'(depth - lo)) / 32'(hi - lo);
      if (v >= SEG_END) v = SEG_END;
    end
    lb = v[7:0];
    if (v < SEG_END) begin
      case (v[10:8])
        drcm_pkg::SEG_WHITE_RED: begin
          c.red   = drcm_pkg::CHAN_MAX;
          c.green = drcm_pkg::CHAN_MAX - lb;
          c.blue  = drcm_pkg::CHAN_MAX - lb;
        end
        drcm_pkg::SEG_RED_YELLOW: begin
          c.red = drcm_pkg::CHAN_MAX; c.green = lb; c.blue = '0;
        end
        drcm_pkg::SEG_YELLOW_GRN: begin
          c.red = drcm_pkg::CHAN_MAX - lb; c.green = drcm_pkg::CHAN_MAX; c.blue = '0;
        end
        drcm_pkg::SEG_GRN_CYAN: begin
          c.red = '0; c.green = drcm_pkg::CHAN_MAX; c.blue = lb;
        end
        drcm_pkg::SEG_CYAN_BLUE: begin
          c.red = '0; c.green = drcm_pkg::CHAN_MAX - lb; c.blue = drcm_pkg::CHAN_MAX;
        end
        drcm_pkg::SEG_BLUE_BLACK: begin
          c.red = '0; c.green = '0; c.blue = drcm_pkg::CHAN_MAX - lb;
        end
        default: c = '0;
      endcase
    end
    if (v == 0) c = '0;
    return c;
  endfunction

  // mostly inside the ramp, some around its ends, some anywhere
  function automatic logic [drcm_pkg::SAMPLE_BITS-1:0] pick_depth(
      input logic [drcm_pkg::SAMPLE_BITS-1:0] lo,
      input logic [drcm_pkg::SAMPLE_BITS-1:0] hi);
    int unsigned span;
    int          d;
    span = (hi > lo) ? int'(hi) - int'(lo) : 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: d = int'(lo) + int'($urandom_range(0, span));
      6:       d = int'(lo) + int'($urandom_range(0, 8)) - 4;
      7:       d = int'(hi) + int'($urandom_range(0, 12)) - 2;
      default: d = int'($urandom_range(0, 65535));
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[drcm_pkg::SAMPLE_BITS-1:0];
  endfunction

  task automatic write_reg(input logic [drcm_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [drcm_pkg::SAMPLE_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == drcm_pkg::REG_RANGE_LOW) ramp_low = val;
    else ramp_high = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled away from the rising edge so the driver's pop and valid agree
  task automatic wait_idle();
    while (depth_backlog.size() != 0 || s_tvalid || expected_colors.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_range(input logic [drcm_pkg::SAMPLE_BITS-1:0] lo,
                           input logic [drcm_pkg::SAMPLE_BITS-1:0] hi);
    wait_idle();
    write_reg(drcm_pkg::REG_RANGE_LOW, lo);
    write_reg(drcm_pkg::REG_RANGE_HIGH, hi);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (depth_backlog.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= depth_backlog.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 64);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode now and then; one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_tick++;
      if (!long_hold_done && colors_checked >= HOLD_TRIGGER) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= (stall_tick % 5 >= 2);
        endcase
      end
    end
  end

  // predict on input beats, check on output beats
  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_colors.push_back(
          rainbow_color(s_tdata[drcm_pkg::SAMPLE_BITS-1:0], ramp_low, ramp_high));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_colors.size() == 0) begin
          $error("unexpected output beat: rgb=%h", got);
          mismatch_count++;
        end else begin
          want = expected_colors.pop_front();
          colors_checked++;
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            mismatch_count++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            mismatch_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [drcm_pkg::SAMPLE_BITS-1:0] set_lo[NUM_SETS];
    logic [drcm_pkg::SAMPLE_BITS-1:0] set_hi[NUM_SETS];
    int unsigned                      p;
    int unsigned                      k;
    int unsigned                      span;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // span of 1530 makes v equal to depth - low: walk every segment edge
    set_range(16'd1000, 16'd2530);
    depth_backlog.push_back(16'd0);
    depth_backlog.push_back(16'd999);
    depth_backlog.push_back(16'd1000);
    depth_backlog.push_back(16'd1001);
    depth_backlog.push_back(16'd1255);
    depth_backlog.push_back(16'd1256);
    depth_backlog.push_back(16'd1511);
    depth_backlog.push_back(16'd1512);
    depth_backlog.push_back(16'd1767);
    depth_backlog.push_back(16'd1768);
    depth_backlog.push_back(16'd2023);
    depth_backlog.push_back(16'd2024);
    depth_backlog.push_back(16'd2279);
    depth_backlog.push_back(16'd2280);
    depth_backlog.push_back(16'd2529);
    depth_backlog.push_back(16'd2530);
    depth_backlog.push_back(16'd2531);
    depth_backlog.push_back(16'd2535);
    depth_backlog.push_back(16'd2536);
    depth_backlog.push_back(16'd65535);

    // empty range, equal bounds then inverted
    set_range(16'd5000, 16'd5000);
    depth_backlog.push_back(16'd5001);
    depth_backlog.push_back(16'd65535);
    set_range(16'd6000, 16'd5000);
    depth_backlog.push_back(16'd5500);
    depth_backlog.push_back(16'd6001);

    set_lo[0] = 16'd0;     set_hi[0] = 16'd65535;
    set_lo[1] = 16'd0;     set_hi[1] = 16'd1;
    set_lo[2] = 16'd65534; set_hi[2] = 16'd65535;
    set_lo[3] = 16'd65535; set_hi[3] = 16'd0;
    set_lo[4] = 16'd1000;  set_hi[4] = 16'd2530;
    set_lo[5] = 16'd300;   set_hi[5] = 16'd303;
    for (p = 6; p < 8; p++) begin
      set_lo[p] = 16'($urandom_range(0, 60000));
      span      = $urandom_range(1, 5000);
      set_hi[p] = (int'(set_lo[p]) + span > 65535) ? 16'd65535 : 16'(set_lo[p] + span);
    end
    set_lo[8] = 16'($urandom_range(0, 65535));
    set_hi[8] = 16'($urandom_range(0, 65535));

    for (p = 0; p < NUM_SETS; p++) begin
      set_range(set_lo[p], set_hi[p]);
      for (k = 0; k < ITEMS_PER_SET; k++)
        depth_backlog.push_back(pick_depth(set_lo[p], set_hi[p]));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_colors.size() != 0) begin
      $error("%0d expected pixels never came out", expected_colors.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
